### hw/rtl/brcs_pkg.sv
// ---------------------------------------------------------------------------
// Bayer region color sums: shared package
// Sizes, register codes and shared types of the Bayer window statistics block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brcs_pkg;

  localparam int MAX_ROW_LENGTH = 2048;
  localparam int MAX_ROWS       = 2048;

  localparam int PIX_W  = 8;
  localparam int REG_W  = 12;
  localparam int SUM_W  = 28;
  localparam int IDX_W  = 3;

  localparam int COL_W      = $clog2(MAX_ROW_LENGTH);
  localparam int LEN_W      = $clog2(MAX_ROW_LENGTH + 1);
  localparam int CELL_W     = COL_W - 1;
  localparam int LINE_CELLS = MAX_ROW_LENGTH / 2;
  localparam int ROW_W      = $clog2(MAX_ROWS + 1);
  localparam int MAX_AB_W   = (REG_W > LEN_W) ? REG_W : LEN_W;
  localparam int CMP_W      = ((MAX_AB_W > ROW_W) ? MAX_AB_W : ROW_W) + 1;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [REG_W-1:0] RST_ROW_LENGTH    = 12'd2048;
  localparam logic [REG_W-1:0] RST_WINDOW_TOP    = 12'd0;
  localparam logic [REG_W-1:0] RST_WINDOW_BOTTOM = 12'd2048;
  localparam logic [REG_W-1:0] RST_WINDOW_LEFT   = 12'd0;
  localparam logic [REG_W-1:0] RST_WINDOW_RIGHT  = 12'd2048;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW_LENGTH    = 3'd0,
    REG_WINDOW_TOP    = 3'd1,
    REG_WINDOW_BOTTOM = 3'd2,
    REG_WINDOW_LEFT   = 3'd3,
    REG_WINDOW_RIGHT  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_RED   = 2'd1,
    KIND_GREEN = 2'd2,
    KIND_BLUE  = 2'd3
  } sample_kind_t;

  typedef struct packed {
    logic [REG_W-1:0] row_length;
    logic [REG_W-1:0] window_top;
    logic [REG_W-1:0] window_bottom;
    logic [REG_W-1:0] window_left;
    logic [REG_W-1:0] window_right;
  } cfg_regs_t;

  // One classified pixel on its way to the accumulators.
  typedef struct packed {
    logic               frame_first;
    logic               frame_last;
    sample_kind_t       kind;
    logic [PIX_W-1:0]   pix;
  } stage_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                               input logic [PIX_W-1:0] v);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + {{(SUM_W + 1 - PIX_W){1'b0}}, v};
    sat_add = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/brcs_pixel_if.sv
// ---------------------------------------------------------------------------
// Bayer region color sums: pixel channel
// Valid/ready channel carrying one raw pixel and its frame flags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface brcs_pixel_if
  import brcs_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;
  logic             frame_end;

  modport source (output valid, output pixel, output frame_start, output frame_end,
                  input ready);
  modport sink   (input valid, input pixel, input frame_start, input frame_end,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/brcs_sums_if.sv
// ---------------------------------------------------------------------------
// Bayer region color sums: result channel
// Valid/ready channel carrying the three color sums of one frame.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface brcs_sums_if
  import brcs_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] red_sum;
  logic [SUM_W-1:0] green_sum;
  logic [SUM_W-1:0] blue_sum;

  modport source (output valid, output red_sum, output green_sum, output blue_sum,
                  input ready);
  modport sink   (input valid, input red_sum, input green_sum, input blue_sum,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/brcs_cfg_if.sv
// ---------------------------------------------------------------------------
// Bayer region color sums: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface brcs_cfg_if
  import brcs_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [REG_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/brcs_locate.sv
// ---------------------------------------------------------------------------
// Bayer region color sums: pixel locator
// Tracks column and row, classifies each pixel against the window and holds
// the even-row greens in a one-line store for the odd row.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brcs_locate
  import brcs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             take,
  input  wire logic [PIX_W-1:0] pixel,
  input  wire logic             frame_start,
  input  wire logic             frame_end,
  input  wire cfg_regs_t        cfg,
  output stage_t                stage_r,
  output logic [PIX_W-1:0]      g1_r
);

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [PIX_W-1:0]  line_mem [LINE_CELLS];

  logic [CMP_W-1:0]  rl_ext, len_c, col_ext, col_use;
  logic [COL_W-1:0]  col_cur, col;
  logic [ROW_W-1:0]  row_cur;
  logic [CELL_W-1:0] cx;
  logic [ROW_W-2:0]  cy;
  logic              counting, in_window, line_end, wr_en;
  sample_kind_t      kind;

  always_comb begin
    // Effective line length: clamped to the legal range and forced even.
    rl_ext = CMP_W'(cfg.row_length);
    if (rl_ext < CMP_W'(2)) begin
      len_c = CMP_W'(2);
    end else if (rl_ext > CMP_W'(MAX_ROW_LENGTH)) begin
      len_c = CMP_W'(MAX_ROW_LENGTH);
    end else begin
      len_c = rl_ext;
    end
    len_c[0] = 1'b0;

    col_cur = frame_start ? '0 : col_r;
    row_cur = frame_start ? '0 : row_r;

    // A column beyond a shortened line counts as the last pixel of the line.
    col_ext = CMP_W'(col_cur);
    col_use = (col_ext >= len_c) ? (len_c - CMP_W'(1)) : col_ext;
    col     = col_use[COL_W-1:0];

    counting = CMP_W'(row_cur) < CMP_W'(MAX_ROWS);
    cx = col[COL_W-1:1];
    cy = row_cur[ROW_W-1:1];
    in_window = (CMP_W'(cy) >= CMP_W'(cfg.window_top[REG_W-1:1])) &&
                (CMP_W'(cy) <  CMP_W'(cfg.window_bottom[REG_W-1:1])) &&
                (CMP_W'(cx) >= CMP_W'(cfg.window_left[REG_W-1:1])) &&
                (CMP_W'(cx) <  CMP_W'(cfg.window_right[REG_W-1:1]));

    kind  = KIND_NONE;
    wr_en = 1'b0;
    if (counting) begin
      unique case ({row_cur[0], col[0]})
        2'b00: kind = in_window ? KIND_RED : KIND_NONE;
        2'b01: wr_en = take;
        2'b10: kind = in_window ? KIND_GREEN : KIND_NONE;
        2'b11: kind = in_window ? KIND_BLUE : KIND_NONE;
        default: kind = KIND_NONE;
      endcase
    end

    line_end = (CMP_W'(col) + CMP_W'(1)) >= len_c;
    col_nxt  = col_cur;
    row_nxt  = row_cur;
    if (counting) begin
      if (line_end) begin
        col_nxt = '0;
        row_nxt = row_cur + ROW_W'(1);
      end else begin
        col_nxt = col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (take) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[cx] <= pixel;
    end
    if (take) begin
      g1_r    <= line_mem[cx];
      stage_r <= '{frame_first: frame_start, frame_last: frame_end,
                   kind: kind, pix: pixel};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bayer_region_color_sums.sv
// A frame-end item's sums pass the stage register and then the result register to out_sums.
// Throughput: one pixel per cycle while in_ready is high; the line store has one read and one write port.
// in_ready drops only while a frame-end item waits behind an untaken result.
// Reset (synchronous, rst_n low) clears position, sums, pipeline valids and
// restores the register defaults; the green line store is not cleared.
// ---------------------------------------------------------------------------
// Bayer region color sums: top level
// Sums R, B and the green pair average over the window cells of an RGGB frame.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bayer_region_color_sums
  import brcs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  brcs_pixel_if.sink in_pix,
  brcs_sums_if.source out_sums,
  brcs_cfg_if.sink   cfg_wr
);

  cfg_regs_t        cfg_r;
  stage_t           stage_r;
  logic [PIX_W-1:0] g1_r;
  logic             b_valid_r;
  logic             b_hold, b_fire, emit, in_fire;
  logic [SUM_W-1:0] red_total_r, green_total_r, blue_total_r;
  logic [SUM_W-1:0] red_nxt, green_nxt, blue_nxt;
  logic [SUM_W-1:0] red_base, green_base, blue_base;
  logic [PIX_W:0]   g_pair;
  logic             out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0] red_sum_r, green_sum_r, blue_sum_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{row_length: RST_ROW_LENGTH, window_top: RST_WINDOW_TOP,
                 window_bottom: RST_WINDOW_BOTTOM, window_left: RST_WINDOW_LEFT,
                 window_right: RST_WINDOW_RIGHT};
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_ROW_LENGTH:    cfg_r.row_length    <= cfg_wr.data;
        REG_WINDOW_TOP:    cfg_r.window_top    <= cfg_wr.data;
        REG_WINDOW_BOTTOM: cfg_r.window_bottom <= cfg_wr.data;
        REG_WINDOW_LEFT:   cfg_r.window_left   <= cfg_wr.data;
        REG_WINDOW_RIGHT:  cfg_r.window_right  <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // Only a frame-end item needs the result register; other items flow past it.
  assign b_hold       = b_valid_r && stage_r.frame_last && out_valid_r && !out_sums.ready;
  assign b_fire       = b_valid_r && !b_hold;
  assign emit         = b_fire && stage_r.frame_last;
  assign in_pix.ready = !b_hold;
  assign in_fire      = in_pix.valid && in_pix.ready;

  brcs_locate u_locate (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (in_fire),
    .pixel      (in_pix.pixel),
    .frame_start(in_pix.frame_start),
    .frame_end  (in_pix.frame_end),
    .cfg        (cfg_r),
    .stage_r    (stage_r),
    .g1_r       (g1_r)
  );

  always_comb begin
    red_base   = stage_r.frame_first ? '0 : red_total_r;
    green_base = stage_r.frame_first ? '0 : green_total_r;
    blue_base  = stage_r.frame_first ? '0 : blue_total_r;
    g_pair     = {1'b0, g1_r} + {1'b0, stage_r.pix};
    red_nxt    = red_base;
    green_nxt  = green_base;
    blue_nxt   = blue_base;
    unique case (stage_r.kind)
      KIND_RED:   red_nxt   = sat_add(red_base, stage_r.pix);
      KIND_GREEN: green_nxt = sat_add(green_base, g_pair[PIX_W:1]);
      KIND_BLUE:  blue_nxt  = sat_add(blue_base, stage_r.pix);
      default: ;
    endcase
    out_valid_nxt = emit ? 1'b1 : (out_sums.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      red_total_r   <= '0;
      green_total_r <= '0;
      blue_total_r  <= '0;
    end else begin
      b_valid_r   <= in_fire ? 1'b1 : (b_fire ? 1'b0 : b_valid_r);
      out_valid_r <= out_valid_nxt;
      if (b_fire) begin
        red_total_r   <= red_nxt;
        green_total_r <= green_nxt;
        blue_total_r  <= blue_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      red_sum_r   <= red_nxt;
      green_sum_r <= green_nxt;
      blue_sum_r  <= blue_nxt;
    end
  end

  assign out_sums.valid     = out_valid_r;
  assign out_sums.red_sum   = red_sum_r;
  assign out_sums.green_sum = green_sum_r;
  assign out_sums.blue_sum  = blue_sum_r;

endmodule

`default_nettype wire

### hw/rtl/brcs_checker.sv
// ---------------------------------------------------------------------------
// Bayer region color sums: port checker
// Concurrent checks on the top-level pixel and result channels, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brcs_checker
  import brcs_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             in_frame_end,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [SUM_W-1:0] out_red_sum,
  input wire logic [SUM_W-1:0] out_green_sum,
  input wire logic [SUM_W-1:0] out_blue_sum
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_red_sum) && $stable(out_green_sum) && $stable(out_blue_sum))
    else $error("stalled result item changed");

  // A fresh result is caused by an accepted frame-end item.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_frame_end, 2))
    else $error("result item without a frame-end item");

  // Input backpressure only comes from an untaken result.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while result side is free");

endmodule

bind bayer_region_color_sums brcs_checker u_brcs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_pix.valid),
  .in_ready     (in_pix.ready),
  .in_frame_end (in_pix.frame_end),
  .out_valid    (out_sums.valid),
  .out_ready    (out_sums.ready),
  .out_red_sum  (out_sums.red_sum),
  .out_green_sum(out_sums.green_sum),
  .out_blue_sum (out_sums.blue_sum)
);

`default_nettype wire
